// ===== rtl/core/hsbm_pkg.sv =====
// Package for the humidity sensor bus master.
// Holds the item, result and configuration structs, the sequencer phase type and codes.
// No dependencies.
package hsbm_pkg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_value;
        logic       data_line_in;
    } t_in;

    typedef struct packed {
        logic        clock_out;
        logic        data_drive_enable;
        logic        data_level_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] result_word;
        logic [7:0]  result_checksum;
        logic [1:0]  error_count;
    } t_out;

    typedef struct packed {
        logic [7:0]  bit_half_ticks;
        logic [9:0]  start_phase_ticks;
        logic [9:0]  poll_interval_ticks;
        logic [15:0] poll_limit;
    } t_cfg;

    typedef enum logic [19:0] {
        PH_IDLE   = 20'h00001,
        PH_RST_HI = 20'h00002,
        PH_RST_LO = 20'h00004,
        PH_TS0    = 20'h00008,
        PH_TS1    = 20'h00010,
        PH_TS2    = 20'h00020,
        PH_TS3    = 20'h00040,
        PH_TS4    = 20'h00080,
        PH_TS5    = 20'h00100,
        PH_TS6    = 20'h00200,
        PH_W_SET  = 20'h00400,
        PH_W_HIGH = 20'h00800,
        PH_W_LOW  = 20'h01000,
        PH_W_ACK  = 20'h02000,
        PH_W_TAIL = 20'h04000,
        PH_POLL   = 20'h08000,
        PH_R_HIGH = 20'h10000,
        PH_R_LOW  = 20'h20000,
        PH_R_ACK  = 20'h40000,
        PH_R_TAIL = 20'h80000
    } t_phase;

    localparam logic [2:0] OP_NONE         = 3'd0;
    localparam logic [2:0] OP_CONN_RESET   = 3'd1;
    localparam logic [2:0] OP_SOFT_RESET   = 3'd2;
    localparam logic [2:0] OP_MEAS_TEMP    = 3'd3;
    localparam logic [2:0] OP_MEAS_HUMI    = 3'd4;
    localparam logic [2:0] OP_READ_STATUS  = 3'd5;
    localparam logic [2:0] OP_WRITE_STATUS = 3'd6;

    localparam logic [7:0] CMD_SOFT_RESET   = 8'h1e;
    localparam logic [7:0] CMD_MEAS_TEMP    = 8'h03;
    localparam logic [7:0] CMD_MEAS_HUMI    = 8'h05;
    localparam logic [7:0] CMD_READ_STATUS  = 8'h07;
    localparam logic [7:0] CMD_WRITE_STATUS = 8'h06;

    localparam logic [1:0] CFG_BIT_HALF      = 2'd0;
    localparam logic [1:0] CFG_START_PHASE   = 2'd1;
    localparam logic [1:0] CFG_POLL_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_POLL_LIMIT    = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/core/hsbm_seq.sv =====
// Bus sequencer for the humidity sensor bus master.
// Holds the phase and transfer state and computes one result per tick item.
// Depends on hsbm_pkg.
module hsbm_seq #(
    parameter int RESET_CLOCKS = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  hsbm_pkg::t_in  i_item,
    input  hsbm_pkg::t_cfg i_cfg,
    output hsbm_pkg::t_out o_result
);
    import hsbm_pkg::*;

    localparam logic [3:0] RESET_COUNT = 4'(RESET_CLOCKS);

    t_phase      r_phase, n_phase, s_phase;
    logic [9:0]  r_tick, n_tick;
    logic [3:0]  r_bit, n_bit, s_bit;
    logic [7:0]  r_shift, n_shift, s_shift;
    logic [1:0]  r_byte, n_byte, s_byte;
    logic [15:0] r_poll, n_poll, s_poll;
    logic [2:0]  r_cmd, n_cmd, s_cmd;
    logic [7:0]  r_value, n_value, s_value;
    logic [15:0] r_word, n_word;
    logic [7:0]  r_csum, n_csum;
    logic [1:0]  r_err, n_err;

    logic        start_cmd;
    logic        clk_lvl, drv_en, drv_lvl, seg_end, done;
    logic [9:0]  seg_len, half_len, start_len, poll_len;
    logic [15:0] limit;
    logic        last_rd;
    logic [3:0]  bit_inc;
    logic [16:0] poll_inc;

    assign start_cmd = (r_phase == PH_IDLE) && (i_item.operation != OP_NONE) &&
                       (i_item.operation <= OP_WRITE_STATUS);

    always_comb begin
        s_phase = r_phase;
        s_cmd   = r_cmd;
        s_value = r_value;
        s_byte  = r_byte;
        s_bit   = r_bit;
        s_poll  = r_poll;
        s_shift = r_shift;
        if (start_cmd) begin
            s_cmd   = i_item.operation;
            s_value = i_item.write_value;
            s_byte  = '0;
            s_bit   = '0;
            s_poll  = '0;
            s_shift = '0;
            if (i_item.operation == OP_CONN_RESET || i_item.operation == OP_SOFT_RESET) begin
                s_phase = PH_RST_HI;
            end else begin
                s_phase = PH_TS0;
            end
        end
    end

    assign half_len  = (i_cfg.bit_half_ticks == '0) ? 10'd1 : {2'b00, i_cfg.bit_half_ticks};
    assign start_len = (i_cfg.start_phase_ticks == '0) ? 10'd1 : i_cfg.start_phase_ticks;
    assign poll_len  = (i_cfg.poll_interval_ticks == '0) ? 10'd1 : i_cfg.poll_interval_ticks;
    assign limit     = (i_cfg.poll_limit == '0) ? 16'd1 : i_cfg.poll_limit;
    assign last_rd   = (s_cmd == OP_READ_STATUS) ? (s_byte >= 2'd1) : (s_byte >= 2'd2);
    assign bit_inc   = s_bit + 4'd1;
    assign poll_inc  = {1'b0, s_poll} + 17'd1;

    always_comb begin
        clk_lvl = 1'b0;
        drv_en  = 1'b0;
        drv_lvl = 1'b0;
        seg_len = half_len;
        case (s_phase)
            PH_RST_HI: begin
                clk_lvl = 1'b1; drv_en = 1'b1; drv_lvl = 1'b1;
            end
            PH_RST_LO: begin
                drv_en = 1'b1; drv_lvl = 1'b1;
            end
            PH_TS0: begin
                drv_en = 1'b1; drv_lvl = 1'b1; seg_len = start_len;
            end
            PH_TS1, PH_TS6: begin
                clk_lvl = 1'b1; drv_en = 1'b1; drv_lvl = 1'b1; seg_len = start_len;
            end
            PH_TS2, PH_TS5: begin
                clk_lvl = 1'b1; drv_en = 1'b1; seg_len = start_len;
            end
            PH_TS3, PH_TS4: begin
                drv_en = 1'b1; seg_len = start_len;
            end
            PH_W_SET, PH_W_LOW: begin
                drv_en = 1'b1; drv_lvl = s_shift[7];
            end
            PH_W_HIGH: begin
                clk_lvl = 1'b1; drv_en = 1'b1; drv_lvl = s_shift[7];
            end
            PH_W_ACK, PH_R_HIGH: begin
                clk_lvl = 1'b1;
            end
            PH_POLL: begin
                seg_len = poll_len;
            end
            PH_R_ACK: begin
                clk_lvl = 1'b1; drv_en = 1'b1; drv_lvl = last_rd;
            end
            default: begin
            end
        endcase
    end

    assign seg_end = (s_phase != PH_IDLE) && (({1'b0, r_tick} + 11'd1) >= {1'b0, seg_len});

    always_comb begin
        n_phase = s_phase;
        n_cmd   = s_cmd;
        n_value = s_value;
        n_byte  = s_byte;
        n_bit   = s_bit;
        n_poll  = s_poll;
        n_shift = s_shift;
        n_word  = r_word;
        n_csum  = r_csum;
        n_err   = r_err;
        n_tick  = r_tick;
        if (start_cmd) begin
            n_tick = '0;
        end
        if (s_phase != PH_IDLE) begin
            n_tick = seg_end ? 10'd0 : n_tick + 10'd1;
        end
        if (seg_end) begin
            case (s_phase)
                PH_RST_HI: n_phase = PH_RST_LO;
                PH_RST_LO: begin
                    if (bit_inc >= RESET_COUNT) begin
                        n_bit   = '0;
                        n_phase = PH_TS0;
                    end else begin
                        n_bit   = bit_inc;
                        n_phase = PH_RST_HI;
                    end
                end
                PH_TS0: n_phase = PH_TS1;
                PH_TS1: n_phase = PH_TS2;
                PH_TS2: n_phase = PH_TS3;
                PH_TS3: n_phase = PH_TS4;
                PH_TS4: n_phase = PH_TS5;
                PH_TS5: n_phase = PH_TS6;
                PH_TS6: begin
                    n_bit   = '0;
                    n_phase = PH_W_SET;
                    case (s_cmd)
                        OP_SOFT_RESET:   n_shift = CMD_SOFT_RESET;
                        OP_MEAS_TEMP:    n_shift = CMD_MEAS_TEMP;
                        OP_MEAS_HUMI:    n_shift = CMD_MEAS_HUMI;
                        OP_READ_STATUS:  n_shift = CMD_READ_STATUS;
                        OP_WRITE_STATUS: n_shift = CMD_WRITE_STATUS;
                        default: begin
                            n_bit   = s_bit;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                PH_W_SET:  n_phase = PH_W_HIGH;
                PH_W_HIGH: n_phase = PH_W_LOW;
                PH_W_LOW: begin
                    n_shift = {s_shift[6:0], 1'b0};
                    n_bit   = bit_inc;
                    n_phase = (bit_inc >= BITS_PER_BYTE) ? PH_W_ACK : PH_W_SET;
                end
                PH_W_ACK: begin
                    if (i_item.data_line_in && r_err != 2'd3) begin
                        n_err = r_err + 2'd1;
                    end
                    n_phase = PH_W_TAIL;
                end
                PH_W_TAIL: begin
                    if (s_cmd == OP_MEAS_TEMP || s_cmd == OP_MEAS_HUMI) begin
                        n_poll  = '0;
                        n_phase = PH_POLL;
                    end else if (s_cmd == OP_READ_STATUS) begin
                        n_byte  = '0;
                        n_bit   = '0;
                        n_shift = '0;
                        n_phase = PH_R_HIGH;
                    end else if (s_cmd == OP_WRITE_STATUS && s_byte == 2'd0) begin
                        n_byte  = 2'd1;
                        n_shift = s_value;
                        n_bit   = '0;
                        n_phase = PH_W_SET;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_POLL: begin
                    if (!i_item.data_line_in) begin
                        n_byte  = '0;
                        n_bit   = '0;
                        n_shift = '0;
                        n_phase = PH_R_HIGH;
                    end else begin
                        n_poll = poll_inc[15:0];
                        if (poll_inc >= {1'b0, limit}) begin
                            if (r_err != 2'd3) begin
                                n_err = r_err + 2'd1;
                            end
                            n_byte  = '0;
                            n_bit   = '0;
                            n_shift = '0;
                            n_phase = PH_R_HIGH;
                        end
                    end
                end
                PH_R_HIGH: begin
                    n_shift = {s_shift[6:0], i_item.data_line_in};
                    n_bit   = bit_inc;
                    n_phase = PH_R_LOW;
                end
                PH_R_LOW: begin
                    if (s_bit >= BITS_PER_BYTE) begin
                        if (s_cmd == OP_READ_STATUS) begin
                            if (s_byte == 2'd0) begin
                                n_word = {8'h00, s_shift};
                            end else begin
                                n_csum = s_shift;
                            end
                        end else begin
                            if (s_byte == 2'd0) begin
                                n_word = {s_shift, 8'h00};
                            end else if (s_byte == 2'd1) begin
                                n_word = {r_word[15:8], s_shift};
                            end else begin
                                n_csum = s_shift;
                            end
                        end
                        n_phase = PH_R_ACK;
                    end else begin
                        n_phase = PH_R_HIGH;
                    end
                end
                PH_R_ACK: n_phase = PH_R_TAIL;
                PH_R_TAIL: begin
                    if (last_rd) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_byte  = s_byte + 2'd1;
                        n_bit   = '0;
                        n_shift = '0;
                        n_phase = PH_R_HIGH;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign done = seg_end && (n_phase == PH_IDLE);

    always_comb begin
        o_result.clock_out         = clk_lvl;
        o_result.data_drive_enable = drv_en;
        o_result.data_level_out    = drv_lvl & drv_en;
        o_result.busy_res          = (n_phase != PH_IDLE);
        o_result.done_res          = done;
        o_result.result_word       = n_word;
        o_result.result_checksum   = n_csum;
        o_result.error_count       = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_byte  <= '0;
            r_poll  <= '0;
            r_cmd   <= '0;
            r_value <= '0;
            r_word  <= '0;
            r_csum  <= '0;
            r_err   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_byte  <= n_byte;
            r_poll  <= n_poll;
            r_cmd   <= n_cmd;
            r_value <= n_value;
            r_word  <= n_word;
            r_csum  <= n_csum;
            r_err   <= n_err;
        end
    end

endmodule

// ===== rtl/core/humidity_sensor_bus_master.sv =====
// Top level of the humidity sensor bus master: configuration registers,
// tick item handshake and result register with a skid stage.
// Depends on hsbm_pkg and hsbm_seq.
// An accepted item's result is registered in the output register or, on a stall, in the skid stage.
// Throughput: one tick item per cycle; the input stalls only while the skid stage is full.
// Reset clears the sequencer to idle, the error count and results to zero,
// and loads the configuration registers with their default values.
module humidity_sensor_bus_master #(
    parameter int RESET_CLOCKS = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hsbm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hsbm_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);
    import hsbm_pkg::*;

    t_cfg r_cfg;
    t_out seq_result;
    t_out r_skid;
    logic r_skid_valid;
    logic r_out_valid;
    t_out r_out;
    logic in_accept, out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid & ~r_skid_valid;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_half_ticks      <= 8'd10;
            r_cfg.start_phase_ticks   <= 10'd100;
            r_cfg.poll_interval_ticks <= 10'd100;
            r_cfg.poll_limit          <= 16'd65535;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BIT_HALF:      r_cfg.bit_half_ticks      <= i_cfg_data[7:0];
                CFG_START_PHASE:   r_cfg.start_phase_ticks   <= i_cfg_data[9:0];
                CFG_POLL_INTERVAL: r_cfg.poll_interval_ticks <= i_cfg_data[9:0];
                CFG_POLL_LIMIT:    r_cfg.poll_limit          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hsbm_seq #(
        .RESET_CLOCKS(RESET_CLOCKS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= seq_result;
            end
        end else if (in_accept) begin
            r_skid <= seq_result;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for humidity_sensor_bus_master, driving one tick item per handshake.
// An item-by-item predictor of the sequencer produces the expected line levels and results.
// Depends on hsbm_pkg and the humidity_sensor_bus_master RTL.
module tb_top;
    import hsbm_pkg::*;

    localparam int         RESET_CLOCKS   = 9;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam logic [2:0] OP_UNUSED      = 3'd7;

    typedef enum {SENSOR_TYPICAL, SENSOR_PROMPT, SENSOR_STUCK} t_sensor;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    humidity_sensor_bus_master #(.RESET_CLOCKS(RESET_CLOCKS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_cfg        cfg_model;
    t_phase      seq_phase;
    logic [9:0]  seg_ticks;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [1:0]  byte_idx;
    logic [15:0] poll_cnt;
    logic [2:0]  cmd_q;
    logic [7:0]  wval_q;
    logic [15:0] word_q;
    logic [7:0]  csum_q;
    logic [1:0]  err_q;

    t_out        bus_results_due[$];
    t_out        due_result;
    int          failures;
    int          results_checked;
    int          ticks_sent;
    int          hold_off_request;
    bit          in_quiet;
    bit          out_quiet;
    t_sensor     sensor_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic reading_last_byte();
        return (cmd_q == OP_READ_STATUS) ? (byte_idx >= 2'd1) : (byte_idx >= 2'd2);
    endfunction

    function automatic void add_error();
        if (err_q != 2'd3) err_q++;
    endfunction

    function automatic void begin_write(input logic [7:0] b);
        shreg = b;
        bit_idx = '0;
        seq_phase = PH_W_SET;
    endfunction

    function automatic void begin_read();
        byte_idx = '0;
        bit_idx = '0;
        shreg = '0;
        seq_phase = PH_R_HIGH;
    endfunction

    function automatic t_out predict_bus_tick(input t_in it);
        t_out        r;
        logic        clk, en, lvl, fin, din;
        int unsigned half, start, poll, lim, seg_len;
        half  = (cfg_model.bit_half_ticks == 0) ? 1 : cfg_model.bit_half_ticks;
        start = (cfg_model.start_phase_ticks == 0) ? 1 : cfg_model.start_phase_ticks;
        poll  = (cfg_model.poll_interval_ticks == 0) ? 1 : cfg_model.poll_interval_ticks;
        lim   = (cfg_model.poll_limit == 0) ? 1 : cfg_model.poll_limit;
        din = it.data_line_in;
        clk = 1'b0;
        en = 1'b0;
        lvl = 1'b0;
        fin = 1'b0;
        if (seq_phase == PH_IDLE && it.operation >= OP_CONN_RESET
                && it.operation <= OP_WRITE_STATUS) begin
            cmd_q = it.operation;
            wval_q = it.write_value;
            byte_idx = '0;
            bit_idx = '0;
            seg_ticks = '0;
            poll_cnt = '0;
            shreg = '0;
            seq_phase = (it.operation <= OP_SOFT_RESET) ? PH_RST_HI : PH_TS0;
        end
        if (seq_phase != PH_IDLE) begin
            seg_len = half;
            case (seq_phase)
                PH_RST_HI: begin clk = 1; en = 1; lvl = 1; end
                PH_RST_LO: begin en = 1; lvl = 1; end
                PH_TS0: begin en = 1; lvl = 1; seg_len = start; end
                PH_TS1: begin clk = 1; en = 1; lvl = 1; seg_len = start; end
                PH_TS2: begin clk = 1; en = 1; seg_len = start; end
                PH_TS3, PH_TS4: begin en = 1; seg_len = start; end
                PH_TS5: begin clk = 1; en = 1; seg_len = start; end
                PH_TS6: begin clk = 1; en = 1; lvl = 1; seg_len = start; end
                PH_W_SET, PH_W_LOW: begin en = 1; lvl = shreg[7]; end
                PH_W_HIGH: begin clk = 1; en = 1; lvl = shreg[7]; end
                PH_W_ACK: clk = 1;
                PH_POLL: seg_len = poll;
                PH_R_HIGH: clk = 1;
                PH_R_ACK: begin clk = 1; en = 1; lvl = reading_last_byte(); end
                default: ;
            endcase
            seg_ticks++;
            if (seg_ticks >= seg_len) begin
                seg_ticks = '0;
                case (seq_phase)
                    PH_RST_HI: seq_phase = PH_RST_LO;
                    PH_RST_LO: begin
                        bit_idx++;
                        if (bit_idx >= RESET_CLOCKS) begin
                            bit_idx = '0;
                            seq_phase = PH_TS0;
                        end else begin
                            seq_phase = PH_RST_HI;
                        end
                    end
                    PH_TS0: seq_phase = PH_TS1;
                    PH_TS1: seq_phase = PH_TS2;
                    PH_TS2: seq_phase = PH_TS3;
                    PH_TS3: seq_phase = PH_TS4;
                    PH_TS4: seq_phase = PH_TS5;
                    PH_TS5: seq_phase = PH_TS6;
                    PH_TS6: begin
                        case (cmd_q)
                            OP_SOFT_RESET:   begin_write(CMD_SOFT_RESET);
                            OP_MEAS_TEMP:    begin_write(CMD_MEAS_TEMP);
                            OP_MEAS_HUMI:    begin_write(CMD_MEAS_HUMI);
                            OP_READ_STATUS:  begin_write(CMD_READ_STATUS);
                            OP_WRITE_STATUS: begin_write(CMD_WRITE_STATUS);
                            default:         seq_phase = PH_IDLE;
                        endcase
                    end
                    PH_W_SET: seq_phase = PH_W_HIGH;
                    PH_W_HIGH: seq_phase = PH_W_LOW;
                    PH_W_LOW: begin
                        shreg = {shreg[6:0], 1'b0};
                        bit_idx++;
                        seq_phase = (bit_idx >= BITS_PER_BYTE) ? PH_W_ACK : PH_W_SET;
                    end
                    PH_W_ACK: begin
                        if (din) add_error();
                        seq_phase = PH_W_TAIL;
                    end
                    PH_W_TAIL: begin
                        if (cmd_q == OP_MEAS_TEMP || cmd_q == OP_MEAS_HUMI) begin
                            poll_cnt = '0;
                            seq_phase = PH_POLL;
                        end else if (cmd_q == OP_READ_STATUS) begin
                            begin_read();
                        end else if (cmd_q == OP_WRITE_STATUS && byte_idx == 2'd0) begin
                            byte_idx = 2'd1;
                            begin_write(wval_q);
                        end else begin
                            seq_phase = PH_IDLE;
                        end
                    end
                    PH_POLL: begin
                        if (!din) begin
                            begin_read();
                        end else begin
                            poll_cnt++;
                            if (poll_cnt >= lim) begin
                                add_error();
                                begin_read();
                            end
                        end
                    end
                    PH_R_HIGH: begin
                        shreg = {shreg[6:0], din};
                        bit_idx++;
                        seq_phase = PH_R_LOW;
                    end
                    PH_R_LOW: begin
                        if (bit_idx >= BITS_PER_BYTE) begin
                            if (cmd_q == OP_READ_STATUS) begin
                                if (byte_idx == 2'd0) word_q = {8'h00, shreg};
                                else csum_q = shreg;
                            end else begin
                                if (byte_idx == 2'd0) word_q = {shreg, 8'h00};
                                else if (byte_idx == 2'd1) word_q[7:0] = shreg;
                                else csum_q = shreg;
                            end
                            seq_phase = PH_R_ACK;
                        end else begin
                            seq_phase = PH_R_HIGH;
                        end
                    end
                    PH_R_ACK: seq_phase = PH_R_TAIL;
                    PH_R_TAIL: begin
                        if (reading_last_byte()) begin
                            seq_phase = PH_IDLE;
                        end else begin
                            byte_idx++;
                            bit_idx = '0;
                            shreg = '0;
                            seq_phase = PH_R_HIGH;
                        end
                    end
                    default: seq_phase = PH_IDLE;
                endcase
                fin = (seq_phase == PH_IDLE);
            end
        end
        r.clock_out         = clk;
        r.data_drive_enable = en;
        r.data_level_out    = en ? lvl : 1'b0;
        r.busy_res          = (seq_phase != PH_IDLE);
        r.done_res          = fin;
        r.result_word       = word_q;
        r.result_checksum   = csum_q;
        r.error_count       = err_q;
        return r;
    endfunction

    // The sensor pulls the line low to acknowledge and to signal a finished measurement.
    function automatic logic sensor_level();
        if (sensor_mode == SENSOR_STUCK) return 1'b1;
        if (seq_phase == PH_W_ACK)
            return (sensor_mode == SENSOR_TYPICAL) && ($urandom_range(0, 7) == 0);
        if (seq_phase == PH_POLL)
            return (sensor_mode == SENSOR_TYPICAL) && ($urandom_range(0, 3) != 0);
        return $urandom_range(0, 1);
    endfunction

    function automatic logic [15:0] pad_upper(input int unsigned v, input int width);
        logic [15:0] noise, mask;
        noise = $urandom;
        mask = 16'hffff << width;
        return (noise & mask) | (v[15:0] & ~mask);
    endfunction

    function automatic int unsigned short_length();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) return 0;
        if (k < 5) return 1;
        return $urandom_range(2, 3);
    endfunction

    task automatic flag_failure(input string what, input logic [15:0] want,
                                input logic [15:0] got);
        failures++;
        if (failures <= 10)
            $display("mismatch at result %0d, %0s: expected %0h, got %0h",
                     results_checked, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) flag_failure(what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bus_results_due.size() == 0) begin
                flag_failure("result with nothing expected", 16'h0, o_out_data.result_word);
            end else begin
                due_result = bus_results_due.pop_front();
                check_field("clock_out", due_result.clock_out, o_out_data.clock_out);
                check_field("data_drive_enable", due_result.data_drive_enable,
                            o_out_data.data_drive_enable);
                check_field("data_level_out", due_result.data_level_out,
                            o_out_data.data_level_out);
                check_field("busy_res", due_result.busy_res, o_out_data.busy_res);
                check_field("done_res", due_result.done_res, o_out_data.done_res);
                check_field("result_word", due_result.result_word, o_out_data.result_word);
                check_field("result_checksum", due_result.result_checksum,
                            o_out_data.result_checksum);
                check_field("error_count", due_result.error_count, o_out_data.error_count);
            end
            results_checked++;
        end
    end

    initial begin : result_drain
        int gap;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_request) @(posedge i_clk);
                hold_off_request = 0;
                i_out_stall <= 1'b0;
            end else if (i_rst_n && o_out_valid && !i_out_stall) begin
                gap = out_quiet ? 0 : $urandom_range(0, 7);
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("** humidity_sensor_bus_master: FAILED **");
        $finish;
    end

    task automatic send_tick(input logic [2:0] op, input logic [7:0] wv);
        int  gap;
        t_in item;
        item.operation    = op;
        item.write_value  = wv;
        item.data_line_in = sensor_level();
        gap = in_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        bus_results_due.push_back(predict_bus_tick(item));
        ticks_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bus_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Offers the command tick, then keeps ticking with random ignored commands until idle.
    task automatic run_command(input logic [2:0] op, input logic [7:0] wv, input int pause_tick);
        int n;
        send_tick(op, wv);
        n = 1;
        while (seq_phase != PH_IDLE) begin
            if (n == pause_tick) settle();
            send_tick($urandom_range(0, 7), $urandom);
            n++;
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BIT_HALF:      cfg_model.bit_half_ticks = val[7:0];
            CFG_START_PHASE:   cfg_model.start_phase_ticks = val[9:0];
            CFG_POLL_INTERVAL: cfg_model.poll_interval_ticks = val[9:0];
            CFG_POLL_LIMIT:    cfg_model.poll_limit = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [15:0] half, input logic [15:0] start,
                                input logic [15:0] poll, input logic [15:0] lim);
        settle();
        cfg_write(CFG_BIT_HALF, half);
        cfg_write(CFG_START_PHASE, start);
        cfg_write(CFG_POLL_INTERVAL, poll);
        cfg_write(CFG_POLL_LIMIT, lim);
    endtask

    task automatic test_idle_line();
        run_command(OP_NONE, 8'h00, 0);
        run_command(OP_UNUSED, 8'hff, 0);
        repeat (3) run_command(OP_NONE, $urandom, 0);
    endtask

    task automatic test_each_command();
        sensor_mode = SENSOR_PROMPT;
        apply_config(16'd1, 16'd1, 16'd1, 16'd4);
        run_command(OP_CONN_RESET, 8'h00, 0);
        run_command(OP_SOFT_RESET, 8'h00, 0);
        run_command(OP_MEAS_TEMP, 8'h00, 0);
        run_command(OP_MEAS_HUMI, 8'h00, 0);
        run_command(OP_READ_STATUS, 8'h00, 0);
        run_command(OP_WRITE_STATUS, 8'ha5, 0);
    endtask

    // Zero in the low bits of every register, with the unused upper bits set.
    task automatic test_zero_lengths();
        sensor_mode = SENSOR_TYPICAL;
        apply_config(16'hff00, 16'hfc00, 16'hfc00, 16'h0000);
        run_command(OP_MEAS_HUMI, 8'h00, 0);
    endtask

    task automatic test_missing_ack_and_timeout();
        sensor_mode = SENSOR_STUCK;
        apply_config(16'd1, 16'd1, 16'd3, 16'd3);
        run_command(OP_WRITE_STATUS, 8'h5a, 0);
        run_command(OP_MEAS_TEMP, 8'h00, 0);
    endtask

    task automatic test_backpressure();
        sensor_mode = SENSOR_TYPICAL;
        apply_config(16'd1, 16'd1, 16'd1, 16'd5);
        in_quiet = 1'b1;
        hold_off_request = 80;
        run_command(OP_MEAS_TEMP, $urandom, 40);
        in_quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int         first_tick;
        int         cmds;
        int unsigned k;
        logic [2:0] op;
        first_tick = ticks_sent;
        cmds = 0;
        while (ticks_sent < first_tick + 100) begin
            if (cmds % 4 == 0) begin
                apply_config(pad_upper(short_length(), 8), pad_upper(short_length(), 10),
                             pad_upper(short_length(), 10), $urandom_range(0, 6));
                k = $urandom_range(0, 7);
                if (k == 0) sensor_mode = SENSOR_STUCK;
                else if (k < 3) sensor_mode = SENSOR_PROMPT;
                else sensor_mode = SENSOR_TYPICAL;
            end
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) op = $urandom_range(0, 1) ? OP_UNUSED : OP_NONE;
            else op = $urandom_range(1, 6);
            run_command(op, $urandom, 0);
            cmds++;
        end
        in_quiet = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        failures = 0;
        results_checked = 0;
        ticks_sent = 0;
        hold_off_request = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        sensor_mode = SENSOR_TYPICAL;
        cfg_model.bit_half_ticks = 8'd10;
        cfg_model.start_phase_ticks = 10'd100;
        cfg_model.poll_interval_ticks = 10'd100;
        cfg_model.poll_limit = 16'd65535;
        seq_phase = PH_IDLE;
        seg_ticks = '0;
        bit_idx = '0;
        shreg = '0;
        byte_idx = '0;
        poll_cnt = '0;
        cmd_q = '0;
        wval_q = '0;
        word_q = '0;
        csum_q = '0;
        err_q = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_line();
        test_each_command();
        test_zero_lengths();
        test_missing_ack_and_timeout();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (4) @(posedge i_clk);
        if (bus_results_due.size() != 0)
            flag_failure("results never delivered", bus_results_due.size(), 16'h0);
        if (failures == 0) begin
            $display("** humidity_sensor_bus_master: PASSED **");
        end else begin
            $display("** humidity_sensor_bus_master: FAILED **");
        end
        $finish;
    end

endmodule
